### src/mft_pkg.sv
// ----------------------------------------------------------------------------
// mft_pkg
// Shared types, constants and the quarter-wave sine table for the motor
// frame transform (Clarke / Park and their inverses).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mft_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ANGLE_W    = 16;
    localparam int SINE_DEPTH = 256;    // quarter-wave entries, power of two
    localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
    localparam int POS_W      = SINE_IDX_W + 2;
    localparam int TAB_W      = 15;     // table magnitudes, 0..32767
    localparam int SINE_W     = TAB_W + 1;
    localparam int FRAC_W     = 15;     // Q1.15 coefficients
    localparam int OPND_W     = SAMPLE_W + 1;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = OPND_W + COEF_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int LANES      = 3;

    typedef enum logic [1:0] {
        FUNC_CLARKE  = 2'd0,
        FUNC_ICLARKE = 2'd1,
        FUNC_PARK    = 2'd2,
        FUNC_IPARK   = 2'd3
    } func_t;

    localparam logic signed [COEF_W-1:0] K_INV_SQRT3      = 16'sd18919;
    localparam logic signed [COEF_W-1:0] K_SQRT3_HALF     = 16'sd28378;
    localparam logic signed [COEF_W-1:0] K_NEG_SQRT3_HALF = -16'sd28378;
    localparam logic signed [COEF_W-1:0] K_MINUS_HALF     = -16'sd16384;
    localparam logic signed [COEF_W-1:0] K_HALF           = 16'sd16384;

    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef struct packed {
        func_t                      func;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic signed [SAMPLE_W-1:0] c;
    } item_t;

    typedef struct packed {
        logic signed [SINE_W-1:0] sin_v;
        logic signed [SINE_W-1:0] cos_v;
    } trig_t;

    typedef logic [TAB_W-1:0] sine_tab_t [0:SINE_DEPTH-1];

    // Taylor term divisor (2n)(2n+1)
    function automatic logic [63:0] taylor_div(input logic [63:0] term, input int n);
        logic [63:0] q;
        case (n)
            1:       q = term / 64'd6;
            2:       q = term / 64'd20;
            3:       q = term / 64'd42;
            4:       q = term / 64'd72;
            5:       q = term / 64'd110;
            6:       q = term / 64'd156;
            7:       q = term / 64'd210;
            8:       q = term / 64'd272;
            9:       q = term / 64'd342;
            10:      q = term / 64'd420;
            11:      q = term / 64'd506;
            default: q = term / 64'd600;
        endcase
        return q;
    endfunction

    // sin(pi/2 * k / SINE_DEPTH) in Q1.15, via a Q30 series
    function automatic logic [TAB_W-1:0] sine_entry(input int k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (PI_Q30 * 64'(k)) / (2 * SINE_DEPTH);
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 12; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = taylor_div(term, n);
            if (n[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[TAB_W-1:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t t;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            t[k] = sine_entry(k);
        end
        return t;
    endfunction

    localparam sine_tab_t        SINE_TAB  = build_sine_tab();
    localparam logic [TAB_W-1:0] SINE_PEAK = sine_entry(SINE_DEPTH);

endpackage

### src/mft_sincos.sv
// ----------------------------------------------------------------------------
// mft_sincos
// Quarter-wave table lookup of sine and cosine for an angle; registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mft_sincos (
    input  logic                         clk,
    input  logic [mft_pkg::ANGLE_W-1:0]  angle,
    output mft_pkg::trig_t               trig
);
    import mft_pkg::*;

    logic [POS_W-1:0] sin_pos;
    logic [POS_W-1:0] cos_pos;
    trig_t            trig_next;
    trig_t            trig_reg;

    // Quadrant in the top two bits; odd quadrants read the table mirrored.
    function automatic logic signed [SINE_W-1:0] sine_at(input logic [POS_W-1:0] p);
        logic [SINE_IDX_W-1:0]    idx;
        logic [SINE_IDX_W-1:0]    rev;
        logic [TAB_W-1:0]         mag;
        logic signed [SINE_W-1:0] sv;
        idx = p[SINE_IDX_W-1:0];
        rev = ~idx + 1'b1;
        if (p[SINE_IDX_W])
            mag = (idx == '0) ? SINE_PEAK : SINE_TAB[rev];
        else
            mag = SINE_TAB[idx];
        sv = {1'b0, mag};
        return p[SINE_IDX_W+1] ? -sv : sv;
    endfunction

    assign sin_pos = angle[ANGLE_W-1 -: POS_W];
    assign cos_pos = sin_pos + POS_W'(SINE_DEPTH);

    always_comb
    begin
        trig_next.sin_v = sine_at(sin_pos);
        trig_next.cos_v = sine_at(cos_pos);
    end

    always_ff @(posedge clk)
    begin
        trig_reg <= trig_next;
    end

    assign trig = trig_reg;

endmodule

### src/mft_mac.sv
// ----------------------------------------------------------------------------
// mft_mac
// Picks two operand/coefficient pairs per output lane by function and
// registers the products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mft_mac (
    input  logic                               clk,
    input  mft_pkg::item_t                     item,
    input  mft_pkg::trig_t                     trig,
    output logic signed [mft_pkg::PROD_W-1:0]  p0 [mft_pkg::LANES],
    output logic signed [mft_pkg::PROD_W-1:0]  p1 [mft_pkg::LANES]
);
    import mft_pkg::*;

    logic signed [OPND_W-1:0] op_a;
    logic signed [OPND_W-1:0] op_b;
    logic signed [OPND_W-1:0] op_c;
    logic signed [OPND_W-1:0] op_d;
    logic signed [SINE_W-1:0] s_v;
    logic signed [SINE_W-1:0] c_v;
    logic signed [SINE_W-1:0] neg_s;

    logic signed [OPND_W-1:0] x0 [LANES];
    logic signed [OPND_W-1:0] x1 [LANES];
    logic signed [COEF_W-1:0] k0 [LANES];
    logic signed [COEF_W-1:0] k1 [LANES];

    logic signed [PROD_W-1:0] p0_reg [LANES];
    logic signed [PROD_W-1:0] p1_reg [LANES];

    assign op_a  = {item.a[SAMPLE_W-1], item.a};
    assign op_b  = {item.b[SAMPLE_W-1], item.b};
    assign op_c  = {item.c[SAMPLE_W-1], item.c};
    assign op_d  = op_b - op_c;
    assign s_v   = trig.sin_v;
    assign c_v   = trig.cos_v;
    assign neg_s = -s_v;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            x0[l] = '0;
            x1[l] = '0;
            k0[l] = '0;
            k1[l] = '0;
        end
        case (item.func)
            FUNC_CLARKE:
            begin
                // a * 0.5 + a * 0.5 passes alpha through exactly
                x0[0] = op_a;  k0[0] = K_HALF;
                x1[0] = op_a;  k1[0] = K_HALF;
                x0[1] = op_d;  k0[1] = K_INV_SQRT3;
            end
            FUNC_ICLARKE:
            begin
                x0[0] = op_a;  k0[0] = K_HALF;
                x1[0] = op_a;  k1[0] = K_HALF;
                x0[1] = op_a;  k0[1] = K_MINUS_HALF;
                x1[1] = op_b;  k1[1] = K_SQRT3_HALF;
                x0[2] = op_a;  k0[2] = K_MINUS_HALF;
                x1[2] = op_b;  k1[2] = K_NEG_SQRT3_HALF;
            end
            FUNC_PARK:
            begin
                x0[0] = op_a;  k0[0] = c_v;
                x1[0] = op_b;  k1[0] = s_v;
                x0[1] = op_b;  k0[1] = c_v;
                x1[1] = op_a;  k1[1] = neg_s;
            end
            FUNC_IPARK:
            begin
                x0[0] = op_a;  k0[0] = c_v;
                x1[0] = op_b;  k1[0] = neg_s;
                x0[1] = op_a;  k0[1] = s_v;
                x1[1] = op_b;  k1[1] = c_v;
            end
            default:
            begin
                x0[0] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            p0_reg[l] <= PROD_W'(x0[l]) * PROD_W'(k0[l]);
            p1_reg[l] <= PROD_W'(x1[l]) * PROD_W'(k1[l]);
        end
    end

    assign p0 = p0_reg;
    assign p1 = p1_reg;

endmodule

### src/mft_sat.sv
// ----------------------------------------------------------------------------
// mft_sat
// Sums a product pair, rounds half up out of Q1.15 and clamps to the
// sample range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mft_sat (
    input  logic signed [mft_pkg::PROD_W-1:0]    p0,
    input  logic signed [mft_pkg::PROD_W-1:0]    p1,
    output logic signed [mft_pkg::SAMPLE_W-1:0]  value,
    output logic                                 clamped
);
    import mft_pkg::*;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [SUM_W-1:0] LIM_HI     = SUM_W'(OUT_MAX);
    localparam logic signed [SUM_W-1:0] LIM_LO     = SUM_W'(OUT_MIN);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] rounded;

    assign sum     = SUM_W'(p0) + SUM_W'(p1) + ROUND_HALF;
    assign rounded = sum >>> FRAC_W;    // floor division

    always_comb
    begin
        if (rounded > LIM_HI)
        begin
            value   = OUT_MAX;
            clamped = 1'b1;
        end
        else if (rounded < LIM_LO)
        begin
            value   = OUT_MIN;
            clamped = 1'b1;
        end
        else
        begin
            value   = rounded[SAMPLE_W-1:0];
            clamped = 1'b0;
        end
    end

endmodule

### src/motor_frame_transform.sv
// ----------------------------------------------------------------------------
// motor_frame_transform
// Field-oriented-control frame transforms: Clarke, inverse Clarke, Park and
// inverse Park, chosen per transaction by func.
//
// Usage: drive func, in_a, in_b, in_c and angle with start high; the
// transaction is taken at that clock edge whenever busy is low, and busy is
// never raised, so one transaction can be taken every cycle.
// Each result appears on out_a, out_b, out_c and saturated for exactly one
// cycle with done high, after the input register, sine/cosine lookup,
// product register, then round and clamp into the result register.
// Throughput is one transaction per cycle.
// Results come out in the order taken; the receiver must capture them in
// the done cycle since nothing holds them back.
// Reset clears the pipeline valid bits; transactions in flight are dropped
// and no done pulse follows them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_frame_transform (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          func,
    input  logic signed [mft_pkg::SAMPLE_W-1:0] in_a,
    input  logic signed [mft_pkg::SAMPLE_W-1:0] in_b,
    input  logic signed [mft_pkg::SAMPLE_W-1:0] in_c,
    input  logic [mft_pkg::ANGLE_W-1:0]         angle,
    output logic                                done,
    output logic signed [mft_pkg::SAMPLE_W-1:0] out_a,
    output logic signed [mft_pkg::SAMPLE_W-1:0] out_b,
    output logic signed [mft_pkg::SAMPLE_W-1:0] out_c,
    output logic                                saturated
);
    import mft_pkg::*;

    logic                       v0_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    logic                       done_reg;

    item_t                      item0_reg;
    item_t                      item1_reg;
    logic [ANGLE_W-1:0]         angle0_reg;
    trig_t                      trig;

    logic signed [PROD_W-1:0]   p0 [LANES];
    logic signed [PROD_W-1:0]   p1 [LANES];
    logic signed [SAMPLE_W-1:0] lane_value [LANES];
    logic [LANES-1:0]           lane_clamped;

    logic signed [SAMPLE_W-1:0] out_a_reg;
    logic signed [SAMPLE_W-1:0] out_b_reg;
    logic signed [SAMPLE_W-1:0] out_c_reg;
    logic                       saturated_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        item0_reg.func <= func_t'(func);
        item0_reg.a    <= in_a;
        item0_reg.b    <= in_b;
        item0_reg.c    <= in_c;
        angle0_reg     <= angle;
        item1_reg      <= item0_reg;
    end

    mft_sincos u_sincos (
        .clk   (clk),
        .angle (angle0_reg),
        .trig  (trig)
    );

    mft_mac u_mac (
        .clk  (clk),
        .item (item1_reg),
        .trig (trig),
        .p0   (p0),
        .p1   (p1)
    );

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        mft_sat u_sat (
            .p0      (p0[l]),
            .p1      (p1[l]),
            .value   (lane_value[l]),
            .clamped (lane_clamped[l])
        );
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            out_a_reg     <= lane_value[0];
            out_b_reg     <= lane_value[1];
            out_c_reg     <= lane_value[2];
            saturated_reg <= |lane_clamped;
        end
    end

    assign done      = done_reg;
    assign out_a     = out_a_reg;
    assign out_b     = out_b_reg;
    assign out_c     = out_c_reg;
    assign saturated = saturated_reg;

endmodule

### src/mft_checker.sv
// ----------------------------------------------------------------------------
// mft_checker
// Port-level checks on the motor frame transform, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mft_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [1:0]                          func,
    input logic signed [mft_pkg::SAMPLE_W-1:0] in_a,
    input logic                                done,
    input logic signed [mft_pkg::SAMPLE_W-1:0] out_a,
    input logic signed [mft_pkg::SAMPLE_W-1:0] out_b,
    input logic signed [mft_pkg::SAMPLE_W-1:0] out_c,
    input logic                                saturated
);
    import mft_pkg::*;

    // every transaction gives exactly one result
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("transaction taken without a result");

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without a transaction");

    // forward Clarke passes alpha through and leaves phase c at zero
    a_clarke_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_CLARKE)
            |-> ##4 (out_a == $past(in_a, 4) && out_c == '0))
        else $error("Clarke alpha or c output wrong");

    a_park_c_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_PARK || func == FUNC_IPARK))
            |-> ##4 (out_c == '0))
        else $error("Park result with nonzero c");

    // a clamp leaves at least one output at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (out_a == OUT_MAX || out_a == OUT_MIN ||
                                 out_b == OUT_MAX || out_b == OUT_MIN ||
                                 out_c == OUT_MAX || out_c == OUT_MIN))
        else $error("saturated flag without a clamped output");

endmodule

bind motor_frame_transform mft_checker u_mft_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for motor_frame_transform. A clocked driver feeds
// Clarke, inverse Clarke, Park and inverse Park transactions from a queue,
// with random idle gaps, and a clocked monitor checks every done pulse
// against an in-bench fixed-point model of the four transforms.
// ----------------------------------------------------------------------------

module tb;

    import mft_pkg::*;

    localparam int    QTR_DEPTH   = 256;
    localparam int    NUM_RANDOM  = 1150;
    localparam int    CYCLE_LIMIT = 200000;
    localparam int    DRAIN_LIMIT = 500;
    localparam longint unsigned PI_Q30_C = 64'd3373259426;
    localparam longint C_INV_SQRT3  = 18919;
    localparam longint C_SQRT3_HALF = 28378;
    localparam longint C_NEG_HALF   = -16384;

    typedef struct {
        func_t                      fn;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic signed [SAMPLE_W-1:0] c;
        logic [ANGLE_W-1:0]         ang;
        int                         gap;
    } xact_t;

    typedef struct {
        func_t                      fn;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic signed [SAMPLE_W-1:0] c;
        logic                       sat;
    } frame_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [1:0]                 func = 2'd0;
    logic signed [SAMPLE_W-1:0] in_a = '0;
    logic signed [SAMPLE_W-1:0] in_b = '0;
    logic signed [SAMPLE_W-1:0] in_c = '0;
    logic [ANGLE_W-1:0]         angle = '0;
    logic                       done;
    logic signed [SAMPLE_W-1:0] out_a;
    logic signed [SAMPLE_W-1:0] out_b;
    logic signed [SAMPLE_W-1:0] out_c;
    logic                       saturated;

    xact_t  pending_xacts[$];
    frame_t expected_frames[$];
    int     quarter_sine[0:QTR_DEPTH];
    int     gap_mode = 0;
    int     xacts_total = 0;
    int     xacts_taken = 0;
    int     frames_checked = 0;
    int     frames_clipped = 0;
    int     per_func[4] = '{0, 0, 0, 0};
    int     errors = 0;
    int     cycles = 0;
    int     wait_left = 0;

    motor_frame_transform dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .in_a      (in_a),
        .in_b      (in_b),
        .in_c      (in_c),
        .angle     (angle),
        .done      (done),
        .out_a     (out_a),
        .out_b     (out_b),
        .out_c     (out_c),
        .saturated (saturated)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------- model ----------------

    // Q30 Taylor series of sin(pi/2 * k / depth), scaled to 32767
    function automatic int sine_entry_q15(input int k);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          v;
        x    = (PI_Q30_C * longint'(k)) / (2 * QTR_DEPTH);
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 12; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (sum * 32767 + (longint'(1) << 29)) / (longint'(1) << 30);
        if (v > 32767)
            v = 32767;
        return int'(v);
    endfunction

    // pos is in units of a quarter-wave step over a full turn
    function automatic longint wave_at(input logic [9:0] pos);
        longint m;
        if (pos[8])
            m = quarter_sine[QTR_DEPTH - int'(pos[7:0])];
        else
            m = quarter_sine[int'(pos[7:0])];
        return pos[9] ? -m : m;
    endfunction

    function automatic longint round_q15(input longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic bit out_of_range(input longint v);
        return (v > 32767) || (v < -32768);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clip_q15(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic frame_t transform_frame(input xact_t x);
        longint     a;
        longint     b;
        longint     c;
        longint     sn;
        longint     cs;
        longint     r0;
        longint     r1;
        longint     r2;
        logic [9:0] pos;
        frame_t     f;
        a   = longint'(x.a);
        b   = longint'(x.b);
        c   = longint'(x.c);
        pos = x.ang[ANGLE_W-1 -: 10];
        sn  = wave_at(pos);
        cs  = wave_at(pos + 10'd256);
        r2  = 0;
        case (x.fn)
            FUNC_CLARKE:
            begin
                r0 = a;
                r1 = round_q15((b - c) * C_INV_SQRT3);
            end
            FUNC_ICLARKE:
            begin
                r0 = a;
                r1 = round_q15(a * C_NEG_HALF + b * C_SQRT3_HALF);
                r2 = round_q15(a * C_NEG_HALF - b * C_SQRT3_HALF);
            end
            FUNC_PARK:
            begin
                r0 = round_q15(a * cs + b * sn);
                r1 = round_q15(b * cs - a * sn);
            end
            default:
            begin
                r0 = round_q15(a * cs - b * sn);
                r1 = round_q15(a * sn + b * cs);
            end
        endcase
        f.fn  = x.fn;
        f.a   = clip_q15(r0);
        f.b   = clip_q15(r1);
        f.c   = clip_q15(r2);
        f.sat = out_of_range(r0) || out_of_range(r1) || out_of_range(r2);
        return f;
    endfunction

    // ---------------- stimulus helpers ----------------

    task automatic queue_xact(input func_t fn, input logic signed [SAMPLE_W-1:0] a,
                              input logic signed [SAMPLE_W-1:0] b,
                              input logic signed [SAMPLE_W-1:0] c,
                              input logic [ANGLE_W-1:0] ang);
        xact_t x;
        x.fn  = fn;
        x.a   = a;
        x.b   = b;
        x.c   = c;
        x.ang = ang;
        case (gap_mode)
            0:       x.gap = $urandom_range(0, 18);
            1:       x.gap = 0;
            default: x.gap = $urandom_range(0, 2);
        endcase
        pending_xacts.push_back(x);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // quadrant boundaries get extra weight
    function automatic logic [ANGLE_W-1:0] pick_angle();
        logic [ANGLE_W-1:0] base;
        if ($urandom_range(0, 4) == 0)
        begin
            base = {2'($urandom_range(0, 3)), 14'd0};
            return base + ANGLE_W'($urandom_range(0, 127)) - 16'd64;
        end
        return ANGLE_W'($urandom);
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin : driver
        xact_t  nxt;
        xact_t  cur;
        logic   taken;
        if (!rst_n)
        begin
            start     <= 1'b0;
            func      <= 2'd0;
            in_a      <= '0;
            in_b      <= '0;
            in_c      <= '0;
            angle     <= '0;
            wait_left <= 0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                cur.fn  = func_t'(func);
                cur.a   = in_a;
                cur.b   = in_b;
                cur.c   = in_c;
                cur.ang = angle;
                cur.gap = 0;
                expected_frames.push_back(transform_frame(cur));
                xacts_taken++;
            end
            if (start && !taken)
            begin
                // hold the transaction until busy drops
            end
            else if (wait_left != 0)
            begin
                start     <= 1'b0;
                wait_left <= wait_left - 1;
            end
            else if (pending_xacts.size() != 0)
            begin
                nxt = pending_xacts.pop_front();
                start     <= 1'b1;
                func      <= nxt.fn;
                in_a      <= nxt.a;
                in_b      <= nxt.b;
                in_c      <= nxt.c;
                angle     <= nxt.ang;
                wait_left <= nxt.gap;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin : monitor
        frame_t exp_f;
        if (rst_n && done)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("result with no transaction pending: a=%0d b=%0d c=%0d sat=%0b",
                       out_a, out_b, out_c, saturated);
                errors++;
            end
            else
            begin
                exp_f = expected_frames.pop_front();
                frames_checked++;
                per_func[int'(exp_f.fn)]++;
                if (exp_f.sat)
                    frames_clipped++;
                if (out_a !== exp_f.a)
                begin
                    $error("out_a mismatch (%s): expected %0d, got %0d",
                           exp_f.fn.name(), exp_f.a, out_a);
                    errors++;
                end
                if (out_b !== exp_f.b)
                begin
                    $error("out_b mismatch (%s): expected %0d, got %0d",
                           exp_f.fn.name(), exp_f.b, out_b);
                    errors++;
                end
                if (out_c !== exp_f.c)
                begin
                    $error("out_c mismatch (%s): expected %0d, got %0d",
                           exp_f.fn.name(), exp_f.c, out_c);
                    errors++;
                end
                if (saturated !== exp_f.sat)
                begin
                    $error("saturated mismatch (%s): expected %0b, got %0b",
                           exp_f.fn.name(), exp_f.sat, saturated);
                    errors++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d of %0d transactions taken",
                 cycles, xacts_taken, xacts_total);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------- sequence ----------------

    initial
    begin : main_seq
        int drain;
        for (int k = 0; k <= QTR_DEPTH; k++)
        begin
            quarter_sine[k] = sine_entry_q15(k);
        end

        // directed: extremes, each transform, clipping, ignored fields
        gap_mode = 0;
        queue_xact(FUNC_CLARKE, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'h1234);
        queue_xact(FUNC_CLARKE, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF);
        queue_xact(FUNC_CLARKE, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000);
        queue_xact(FUNC_CLARKE, 16'sh8000, 16'sh4000, 16'shC000, 16'h8000);
        queue_xact(FUNC_ICLARKE, 16'sh8000, 16'sh7FFF, 16'sh5555, 16'hAAAA);
        queue_xact(FUNC_ICLARKE, 16'sh7FFF, 16'sh8000, 16'shAAAA, 16'h5555);
        queue_xact(FUNC_ICLARKE, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'h0000);
        queue_xact(FUNC_ICLARKE, 16'sh4000, 16'sh2000, 16'sh8000, 16'hFFFF);
        queue_xact(FUNC_PARK, 16'sh7FFF, 16'sh0000, 16'sh1111, 16'h0000);
        queue_xact(FUNC_PARK, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'h4000);
        queue_xact(FUNC_PARK, 16'sh8000, 16'sh8000, 16'sh0000, 16'h2000);
        queue_xact(FUNC_PARK, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'h8000);
        queue_xact(FUNC_PARK, 16'sh1234, 16'shEDCB, 16'sh0000, 16'hC000);
        queue_xact(FUNC_PARK, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'hFFFF);
        queue_xact(FUNC_PARK, 16'sh4000, 16'sh4000, 16'sh0000, 16'h3FC0);
        queue_xact(FUNC_IPARK, 16'sh7FFF, 16'sh7FFF, 16'sh2222, 16'h2000);
        queue_xact(FUNC_IPARK, 16'sh8000, 16'sh8000, 16'sh0000, 16'hE000);
        queue_xact(FUNC_IPARK, 16'sh8000, 16'sh0000, 16'sh0000, 16'h0000);
        queue_xact(FUNC_IPARK, 16'sh0000, 16'sh7FFF, 16'sh0000, 16'h4040);
        queue_xact(FUNC_IPARK, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'hBFFF);
        queue_xact(FUNC_IPARK, 16'shFFFF, 16'sh0001, 16'sh0000, 16'h7FFF);

        // random: alternate between sparse, back-to-back and tight traffic
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 64 == 0)
                gap_mode = $urandom_range(0, 2);
            queue_xact(func_t'($urandom_range(0, 3)), pick_sample(), pick_sample(),
                       pick_sample(), pick_angle());
        end
        xacts_total = pending_xacts.size();

        while (xacts_taken < xacts_total)
            @(posedge clk);
        drain = 0;
        while (expected_frames.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (expected_frames.size() != 0)
        begin
            $error("%0d results never arrived", expected_frames.size());
            errors++;
        end

        $display("%0d transactions checked: clarke %0d, inv clarke %0d, park %0d, inv park %0d",
                 frames_checked, per_func[0], per_func[1], per_func[2], per_func[3]);
        $display("%0d results clipped to Q1.15, %0d errors", frames_clipped, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
